>>> rtl/gpl_pkg.sv
`timescale 1ns / 1ps
package gpl_pkg;

    localparam int COEF_W  = 20;
    localparam int INDEX_W = 5;
    localparam int LOC_W   = 17;
    localparam int CH_W    = 16;
    localparam int COLOR_W = 3 * CH_W;
    localparam int COUNT_W = 6;
    localparam int FRAC_W  = 17;
    localparam int DIV_STEPS = FRAC_W;
    localparam int PROD_W  = 35;
    localparam int TDATA_IN_W  = 96;
    localparam int TDATA_OUT_W = 48;
    localparam int ENTRY_W = LOC_W + COLOR_W;

    localparam logic [LOC_W-1:0] Q_ONE = 17'h10000;

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_WRITE  = 1'b1;

    localparam logic CFG_STOP_COUNT = 1'b0;
    localparam logic CFG_FALLBACK   = 1'b1;

    typedef struct packed {
        logic               matched;
        logic [COLOR_W-1:0] ca;
        logic [COLOR_W-1:0] cb;
    } t_side;

endpackage

>>> rtl/gpl_ram.sv
`timescale 1ns / 1ps
module gpl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

>>> rtl/gpl_div.sv
`timescale 1ns / 1ps
module gpl_div
    import gpl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [LOC_W-1:0]  i_rem,
    input  logic [LOC_W-1:0]  i_den,
    input  logic              i_zero,
    input  t_side             i_side,
    output logic              o_valid,
    output logic [FRAC_W-1:0] o_t,
    output t_side             o_side
);

    logic              r_valid [DIV_STEPS];
    logic [LOC_W-1:0]  r_rem   [DIV_STEPS];
    logic [FRAC_W-1:0] r_q     [DIV_STEPS];
    logic [LOC_W-1:0]  r_den   [DIV_STEPS];
    logic              r_zero  [DIV_STEPS];
    t_side             r_side  [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic              valid_in;
        logic [LOC_W-1:0]  rem_in;
        logic [FRAC_W-1:0] q_in;
        logic [LOC_W-1:0]  den_in;
        logic              zero_in;
        t_side             side_in;
        logic [LOC_W:0]    shifted;
        logic              take;
        logic [LOC_W-1:0]  n_rem;
        logic [FRAC_W-1:0] n_q;

        if (k == 0) begin : g_first
            assign valid_in = i_valid;
            assign rem_in   = i_rem;
            assign q_in     = '0;
            assign den_in   = i_den;
            assign zero_in  = i_zero;
            assign side_in  = i_side;
            assign shifted  = {1'b0, rem_in};
        end else begin : g_next
            assign valid_in = r_valid[k-1];
            assign rem_in   = r_rem[k-1];
            assign q_in     = r_q[k-1];
            assign den_in   = r_den[k-1];
            assign zero_in  = r_zero[k-1];
            assign side_in  = r_side[k-1];
            assign shifted  = {rem_in, 1'b0};
        end

        always_comb begin
            take  = shifted >= {1'b0, den_in};
            n_rem = take ? LOC_W'(shifted - {1'b0, den_in}) : LOC_W'(shifted);
            n_q   = q_in;
            n_q[DIV_STEPS-1-k] = take;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= valid_in;
            end
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_q[k]    <= n_q;
                r_den[k]  <= den_in;
                r_zero[k] <= zero_in;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_valid[DIV_STEPS-1];
    assign o_t     = r_zero[DIV_STEPS-1] ? '0 : r_q[DIV_STEPS-1];
    assign o_side  = r_side[DIV_STEPS-1];

endmodule

>>> rtl/gradient_palette_lookup.sv
`timescale 1ns / 1ps
// Gradient palette lookup. Each lookup beat on the slave side yields one color beat on the
// master side; a new beat is taken every cycle when the master side does not stall. The path runs
// through the clamp, bracket compare and search/table read stages, the fraction divider, which
// resolves one quotient bit per stage over 17 stages, and the multiply and output stages. A stop write
// beat gives no result and is held off while a lookup accepted before it sits in the clamp stage.
// Stop locations are kept in flops for the parallel bracket compare and, with the colors, in a
// two-read-port RAM. tuser on the slave side is the kind (0 lookup, 1 write stop); tuser on the
// master side is the matched flag, low when the fallback color is given.
module gradient_palette_lookup
    import gpl_pkg::*;
#(
    parameter int MAX_STOPS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // coefficient, stop_index, stop_location, stop_red, stop_green, stop_blue, zero pad
    input  logic [TDATA_IN_W-1:0]  i_s_axis_tdata,
    // kind
    input  logic                   i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // red, green, blue
    output logic [TDATA_OUT_W-1:0] o_m_axis_tdata,
    // matched
    output logic                   o_m_axis_tuser,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic                   i_cfg_index,
    input  logic [COLOR_W-1:0]     i_cfg_data
);

    localparam int AW = $clog2(MAX_STOPS);

    logic [COEF_W-1:0]  in_coef;
    logic [INDEX_W-1:0] in_index;
    logic [LOC_W-1:0]   in_loc;
    logic [COLOR_W-1:0] in_color;

    assign in_coef  = i_s_axis_tdata[19:0];
    assign in_index = i_s_axis_tdata[24:20];
    assign in_loc   = i_s_axis_tdata[41:25];
    assign in_color = {i_s_axis_tdata[57:42], i_s_axis_tdata[73:58], i_s_axis_tdata[89:74]};

    logic [COUNT_W-1:0] r_stop_count;
    logic [COLOR_W-1:0] r_fallback;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_count <= '0;
            r_fallback   <= '1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_STOP_COUNT: r_stop_count <= i_cfg_data[COUNT_W-1:0];
                CFG_FALLBACK:   r_fallback   <= i_cfg_data;
                default:        r_fallback   <= r_fallback;
            endcase
        end
    end

    logic en;
    logic r_o_valid;
    logic r1_valid;
    logic in_fire;
    logic wr_fire;
    logic lk_fire;
    logic wr_in_range;
    logic [AW-1:0] wr_addr;

    assign en = !r_o_valid || i_m_axis_tready;
    assign o_s_axis_tready = en && !(i_s_axis_tuser == KIND_WRITE && r1_valid);
    assign in_fire = i_s_axis_tvalid && o_s_axis_tready;
    assign wr_fire = in_fire && i_s_axis_tuser == KIND_WRITE;
    assign lk_fire = in_fire && i_s_axis_tuser == KIND_LOOKUP;
    assign wr_in_range = int'(in_index) < MAX_STOPS;
    assign wr_addr = AW'(in_index);

    // location flops for the bracket compare
    logic [LOC_W-1:0] r_loc [MAX_STOPS];

    always_ff @(posedge i_clk) begin
        if (wr_fire && wr_in_range) begin
            r_loc[wr_addr] <= in_loc;
        end
    end

    // stage 1: clamp
    logic [LOC_W-1:0] r1_x;
    logic [LOC_W-1:0] n1_x;

    always_comb begin
        priority if (in_coef[COEF_W-1]) begin
            n1_x = '0;
        end else if (in_coef[COEF_W-2:0] > 19'(Q_ONE)) begin
            n1_x = Q_ONE;
        end else begin
            n1_x = in_coef[LOC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= lk_fire;
        end
        if (en) begin
            r1_x <= n1_x;
        end
    end

    // stage 2: bracket flags per stop pair
    logic                 r2_valid;
    logic [LOC_W-1:0]     r2_x;
    logic [MAX_STOPS-2:0] r2_hit;
    logic [MAX_STOPS-2:0] n2_hit;

    for (genvar i = 0; i < MAX_STOPS - 1; i++) begin : g_pair
        assign n2_hit[i] = (r1_x >= r_loc[i]) && (r1_x <= r_loc[i+1])
                           && ((i + 1) < int'(r_stop_count));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
        if (en) begin
            r2_x   <= r1_x;
            r2_hit <= n2_hit;
        end
    end

    // stage 3: first pair, table read
    logic [AW-1:0] n3_idx;
    logic          n3_found;
    logic          r3_valid;
    logic          r3_found;
    logic [LOC_W-1:0] r3_x;
    logic [ENTRY_W-1:0] rd_a;
    logic [ENTRY_W-1:0] rd_b;

    always_comb begin
        n3_idx   = '0;
        n3_found = 1'b0;
        for (int i = MAX_STOPS - 2; i >= 0; i--) begin
            if (r2_hit[i]) begin
                n3_idx   = AW'(i);
                n3_found = 1'b1;
            end
        end
    end

    gpl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_STOPS)
    ) u_stops (
        .i_clk     (i_clk),
        .i_we      (wr_fire && wr_in_range),
        .i_waddr   (wr_addr),
        .i_wdata   ({in_loc, in_color}),
        .i_re      (en),
        .i_raddr_a (n3_idx),
        .i_raddr_b (n3_idx + AW'(1)),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (en) begin
            r3_valid <= r2_valid;
        end
        if (en) begin
            r3_found <= n3_found;
            r3_x     <= r2_x;
        end
    end

    // fraction divider
    logic [LOC_W-1:0] loc_a;
    logic [LOC_W-1:0] loc_b;
    t_side            div_side_in;
    logic             div_valid;
    logic [FRAC_W-1:0] div_t;
    t_side            div_side;

    assign loc_a = rd_a[ENTRY_W-1:COLOR_W];
    assign loc_b = rd_b[ENTRY_W-1:COLOR_W];
    assign div_side_in = '{matched: r3_found, ca: rd_a[COLOR_W-1:0], cb: rd_b[COLOR_W-1:0]};

    gpl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r3_valid),
        .i_rem   (r3_x - loc_a),
        .i_den   (loc_b - loc_a),
        .i_zero  (loc_b == loc_a),
        .i_side  (div_side_in),
        .o_valid (div_valid),
        .o_t     (div_t),
        .o_side  (div_side)
    );

    // multiply stage
    logic                      r_m_valid;
    logic                      r_m_matched;
    logic [COLOR_W-1:0]        r_m_ca;
    logic signed [PROD_W-1:0]  r_m_prod [3];
    logic signed [PROD_W-1:0]  n_m_prod [3];

    always_comb begin
        logic signed [CH_W:0] diff;
        for (int c = 0; c < 3; c++) begin
            diff = $signed({1'b0, div_side.cb[c*CH_W +: CH_W]})
                 - $signed({1'b0, div_side.ca[c*CH_W +: CH_W]});
            n_m_prod[c] = PROD_W'(diff * $signed({1'b0, div_t}));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (en) begin
            r_m_valid <= div_valid;
        end
        if (en) begin
            r_m_matched <= div_side.matched;
            r_m_ca      <= div_side.ca;
            for (int c = 0; c < 3; c++) begin
                r_m_prod[c] <= n_m_prod[c];
            end
        end
    end

    // output register
    logic [COLOR_W-1:0] r_o_color;
    logic               r_o_matched;
    logic [COLOR_W-1:0] n_o_color;

    always_comb begin
        logic signed [PROD_W:0] sum;
        for (int c = 0; c < 3; c++) begin
            sum = $signed({4'b0, r_m_ca[c*CH_W +: CH_W], 16'b0})
                + (PROD_W+1)'(r_m_prod[c]);
            n_o_color[c*CH_W +: CH_W] = sum[31:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= r_m_valid;
        end
        if (en) begin
            r_o_matched <= r_m_matched;
            r_o_color   <= r_m_matched ? n_o_color : r_fallback;
        end
    end

    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tdata  = {r_o_color[15:0], r_o_color[31:16], r_o_color[47:32]};
    assign o_m_axis_tuser  = r_o_matched;

    a_write_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_fire |-> !r1_valid)
        else $error("stop write taken behind a lookup before its compare");

    a_fallback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_m_valid && !r_m_matched) |=> (r_o_color == $past(r_fallback)))
        else $error("unmatched beat not given the fallback color");

    a_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r2_valid && r2_hit == '0) |=> !r3_found)
        else $error("pair found with no bracket flag set");

endmodule

>>> sim/gradient_palette_lookup_checker.sv
`timescale 1ns / 1ps
module gradient_palette_lookup_checker
    import gpl_pkg::*;
#(
    parameter int MAX_STOPS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_valid,
    input  logic                   i_s_ready,
    input  logic [TDATA_IN_W-1:0]  i_s_data,
    input  logic                   i_s_kind,
    input  logic                   i_m_valid,
    input  logic                   i_m_ready,
    input  logic [TDATA_OUT_W-1:0] i_m_data,
    input  logic                   i_m_matched,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic                   i_cfg_index,
    input  logic [COLOR_W-1:0]     i_cfg_data,
    output int                     o_errors,
    output int                     o_pending
);

    typedef struct packed {
        logic            matched;
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_color;

    logic [LOC_W-1:0]   stop_loc [MAX_STOPS];
    logic [COLOR_W-1:0] stop_rgb [MAX_STOPS];
    logic [COUNT_W-1:0] active_stops;
    logic [COLOR_W-1:0] fallback_rgb;
    t_color             color_queue [$];

    assign o_pending = color_queue.size();

    function automatic logic [CH_W-1:0] blend(logic [CH_W-1:0] ca, logic [CH_W-1:0] cb,
                                              logic [FRAC_W-1:0] t);
        logic [63:0] acc;
        acc = 64'(ca) * (64'd65536 - 64'(t)) + 64'(cb) * 64'(t);
        return acc[31:16];
    endfunction

    function automatic t_color color_of(logic [COEF_W-1:0] coef);
        logic [LOC_W-1:0] x, a, b;
        logic [FRAC_W-1:0] t;
        int n;
        t_color r;
        if (coef[COEF_W-1]) x = '0;
        else if (coef > 20'(Q_ONE)) x = Q_ONE;
        else x = coef[LOC_W-1:0];
        n = (active_stops > MAX_STOPS) ? MAX_STOPS : active_stops;
        r = {1'b0, fallback_rgb};
        for (int i = 0; i + 1 < n; i++) begin
            a = stop_loc[i];
            b = stop_loc[i+1];
            if (x >= a && x <= b) begin
                t = (b > a) ? FRAC_W'((64'(x - a) << 16) / 64'(b - a)) : '0;
                r.matched = 1'b1;
                r.red   = blend(stop_rgb[i][47:32], stop_rgb[i+1][47:32], t);
                r.green = blend(stop_rgb[i][31:16], stop_rgb[i+1][31:16], t);
                r.blue  = blend(stop_rgb[i][15:0], stop_rgb[i+1][15:0], t);
                break;
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_color want;
        if (!i_rst_n) begin
            active_stops <= '0;
            fallback_rgb <= '1;
            o_errors <= 0;
            color_queue.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_STOP_COUNT) active_stops <= i_cfg_data[COUNT_W-1:0];
                else fallback_rgb <= i_cfg_data;
            end
            if (i_s_valid && i_s_ready) begin
                if (i_s_kind == KIND_WRITE) begin
                    stop_loc[i_s_data[24:20]] <= i_s_data[41:25];
                    stop_rgb[i_s_data[24:20]] <= {i_s_data[57:42], i_s_data[73:58],
                                                  i_s_data[89:74]};
                end else begin
                    color_queue.push_back(color_of(i_s_data[COEF_W-1:0]));
                end
            end
            if (i_m_valid && i_m_ready) begin
                if (color_queue.size() == 0) begin
                    $error("unexpected color beat");
                    o_errors <= o_errors + 1;
                end else begin
                    want = color_queue.pop_front();
                    if (want.red != i_m_data[15:0] || want.green != i_m_data[31:16] ||
                        want.blue != i_m_data[47:32] || want.matched != i_m_matched) begin
                        o_errors <= o_errors + 1;
                        if (want.red != i_m_data[15:0])
                            $error("red: expected %0h, got %0h", want.red, i_m_data[15:0]);
                        if (want.green != i_m_data[31:16])
                            $error("green: expected %0h, got %0h", want.green, i_m_data[31:16]);
                        if (want.blue != i_m_data[47:32])
                            $error("blue: expected %0h, got %0h", want.blue, i_m_data[47:32]);
                        if (want.matched != i_m_matched)
                            $error("matched: expected %0b, got %0b", want.matched, i_m_matched);
                    end
                end
            end
        end
    end

endmodule

>>> sim/gradient_palette_lookup_tb.sv
`timescale 1ns / 1ps
module gradient_palette_lookup_tb;
    import gpl_pkg::*;

    localparam int IDLE_LIMIT = 5000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [TDATA_IN_W-1:0]  s_data = '0;
    logic                   s_kind = 1'b0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_data;
    logic                   m_matched;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic                   cfg_index = 1'b0;
    logic [COLOR_W-1:0]     cfg_data = '0;
    int                     errors;
    int                     pending;
    int                     idle_cycles = 0;
    int                     tail;

    always #1 i_clk = ~i_clk;

    gradient_palette_lookup dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data), .i_s_axis_tuser(s_kind),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data), .o_m_axis_tuser(m_matched),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    gradient_palette_lookup_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_valid(s_valid), .i_s_ready(s_ready), .i_s_data(s_data), .i_s_kind(s_kind),
        .i_m_valid(m_valid), .i_m_ready(m_ready), .i_m_data(m_data),
        .i_m_matched(m_matched),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data), .o_errors(errors), .o_pending(pending)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // random receiver stalls
    always @(posedge i_clk) begin
        if (($urandom_range(0, 999) < 3)) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 3) == 0);
    end

    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // valid stays high into a following beat with no gap
    task automatic send(logic kind, logic [TDATA_IN_W-1:0] data);
        int gap;
        gap = gap_len();
        cfg_valid <= 1'b0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_data  <= data;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
    endtask

    task automatic lookup(logic [COEF_W-1:0] coef);
        logic [TDATA_IN_W-1:0] d;
        d = {$urandom, $urandom, $urandom};
        d[COEF_W-1:0] = coef;
        send(KIND_LOOKUP, d);
    endtask

    task automatic write_stop(int idx, logic [LOC_W-1:0] loc, logic [COLOR_W-1:0] rgb);
        logic [TDATA_IN_W-1:0] d;
        d = '0;
        d[19:0] = 20'($urandom);
        d[24:20] = 5'(idx);
        d[41:25] = loc;
        d[89:42] = rgb;
        send(KIND_WRITE, d);
    endtask

    task automatic drain();
        s_valid   <= 1'b0;
        cfg_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [COLOR_W-1:0] value);
        s_valid   <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
    endtask

    function automatic logic [COEF_W-1:0] rand_coef();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return 20'($urandom_range(0, 65536));
        if (r < 8) return 20'($urandom);
        if (r < 9) return {1'b1, 19'($urandom)};
        return 20'($urandom_range(65530, 65542));
    endfunction

    // sorted stops with occasional duplicates and out-of-order entries
    task automatic load_gradient(int n);
        logic [LOC_W-1:0] loc;
        loc = '0;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) loc = 17'($urandom_range(0, 65536));
            else if ($urandom_range(0, 5) != 0) loc = loc + 17'($urandom_range(0, 65536 / n));
            if (loc > Q_ONE) loc = Q_ONE;
            if (i == n - 1 && $urandom_range(0, 1)) loc = Q_ONE;
            write_stop(i, loc, {$urandom, $urandom});
        end
    endtask

    initial begin
        int count;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fewer than two stops: fallback
        lookup(20'h08000);
        drain();
        write_reg(CFG_FALLBACK, 48'h123456789abc);
        write_reg(CFG_STOP_COUNT, 6'd1);
        write_stop(0, '0, '1);
        lookup(20'h00000);
        drain();
        // full extremes plus a zero-width segment
        write_stop(1, 17'h08000, 48'h0);
        write_stop(2, 17'h08000, 48'hffff0000ffff);
        write_stop(3, Q_ONE, 48'h0000ffff0000);
        write_stop(31, 17'h1ffff, 48'hffffffffffff);
        write_reg(CFG_STOP_COUNT, 6'd4);
        lookup(20'h80000);
        lookup(20'h7ffff);
        lookup(20'h10000);
        lookup(20'h10001);
        lookup(20'h08000);
        lookup(20'h04000);
        lookup(20'h0c000);
        lookup(20'hfffff);
        lookup(20'h00001);
        drain();
        // count above the table size acts as full table
        for (int i = 4; i < 31; i++) write_stop(i, Q_ONE, {$urandom, $urandom});
        write_reg(CFG_STOP_COUNT, 6'd63);
        write_reg(CFG_FALLBACK, 48'h0);
        lookup(20'h10000);
        lookup(20'h0ffff);
        drain();

        for (int phase = 0; phase < 12; phase++) begin
            count = (phase % 4 == 0) ? 32 : $urandom_range(2, 12);
            load_gradient(count);
            write_reg(CFG_FALLBACK, {$urandom, $urandom});
            if (phase == 5) write_reg(CFG_STOP_COUNT, 6'd0);
            else if (phase == 7) write_reg(CFG_STOP_COUNT, 6'd63);
            else write_reg(CFG_STOP_COUNT, 6'($urandom_range(0, 2) == 0 ? 32 : count));
            for (int k = 0; k < 112; k++) begin
                if ($urandom_range(0, 15) == 0)
                    write_stop($urandom_range(0, count - 1), 17'($urandom_range(0, 65536)),
                               {$urandom, $urandom});
                else
                    lookup(rand_coef());
            end
            drain();
        end
        drain();
        tail = 0;
        while (pending != 0 && tail < 2000) begin
            @(posedge i_clk);
            tail++;
        end
        if (errors == 0 && pending == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/gpl_pkg.sv
rtl/gpl_ram.sv
rtl/gpl_div.sv
rtl/gradient_palette_lookup.sv
sim/gradient_palette_lookup_checker.sv
sim/gradient_palette_lookup_tb.sv
